### src/csvfs_pkg.sv
// Shared types, character codes and register indexes of the CSV field splitter.
package csvfs_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HAS_HEADER = 1'b1;

    localparam logic [7:0] SEP_RESET = 8'd44;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_EOS  = 1'b1;

    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_NEL   = 8'h85;
    localparam logic [7:0] CH_NBSP  = 8'hA0;

    typedef enum logic [1:0] {
        QM_NORMAL = 2'd0,
        QM_QUOTED = 2'd1,
        QM_QSEEN  = 2'd2
    } t_qmode;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_FLUSH = 1'b1
    } t_state;

    typedef struct packed {
        logic       action;
        logic [7:0] ch;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_char;
        logic        char_valid;
        logic        end_of_field;
        logic        end_of_record;
        logic [7:0]  field_number;
        logic [15:0] record_number;
        logic        is_header;
        logic [8:0]  max_columns;
        logic        space_overflow;
        logic        empty_error;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic flush_step;
        logic in_flush;
    } t_dp_cmd;

    typedef struct packed {
        logic q_full;
        logic need_flush;
        logic flush_last;
    } t_dp_sts;

    function automatic logic is_space(input logic [7:0] c);
        return (c >= CH_HT && c <= CH_CR) || c == CH_SPACE || c == CH_NEL || c == CH_NBSP;
    endfunction

endpackage

### src/csvfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module csvfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/csvfs_outq.sv
// Two-entry result queue that decouples result production from the output stall.
module csvfs_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  csvfs_pkg::t_out_item i_item,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output csvfs_pkg::t_out_item o_out_data,
    output logic                 o_full
);

    csvfs_pkg::t_out_item r_mem [2];
    logic                 r_wp;
    logic                 r_rp;
    logic [1:0]           r_cnt;
    logic [1:0]           n_cnt;
    logic                 pop;

    assign pop = (r_cnt != 2'd0) && !i_out_stall;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_mem[r_rp];
    assign o_full      = (r_cnt == 2'd2);

endmodule

### src/csvfs_datapath.sv
// Datapath: parser state, whitespace buffer, field/record counters and result queue.
module csvfs_datapath #(
    parameter int SPACE_DEPTH = 16,
    parameter int MAX_FIELDS  = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  csvfs_pkg::t_dp_cmd                  i_cmd,
    output csvfs_pkg::t_dp_sts                  o_sts,
    input  csvfs_pkg::t_in_item                 i_in_data,
    input  logic                                i_cfg_we,
    input  logic [csvfs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [csvfs_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output csvfs_pkg::t_out_item                o_out_data
);

    localparam int SC_W   = $clog2(SPACE_DEPTH + 1);
    localparam int SA_W   = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
    localparam int FI_W   = $clog2(MAX_FIELDS);
    localparam int CM_W   = $clog2(MAX_FIELDS + 1);
    localparam int FI_XW  = (FI_W > 8) ? FI_W : 8;
    localparam int CM_XW  = (CM_W > 9) ? CM_W : 9;

    // configuration
    logic [7:0]        r_sep;
    logic              r_hdr;

    // parser state
    csvfs_pkg::t_qmode r_mode,    n_mode;
    logic              r_started, n_started;
    logic              r_lead,    n_lead;
    logic [7:0]        r_held,    n_held;
    logic              r_hvalid,  n_hvalid;
    logic [SC_W-1:0]   r_sc,      n_sc;
    logic              r_ovf,     n_ovf;
    logic [FI_W-1:0]   r_fi,      n_fi;
    logic [15:0]       r_rec,     n_rec;
    logic [CM_W-1:0]   r_colmax,  n_colmax;
    logic              r_line,    n_line;
    logic              r_stream,  n_stream;
    logic [SC_W-1:0]   r_fl_idx,  n_fl_idx;
    logic [SC_W-1:0]   r_fl_cnt,  n_fl_cnt;

    // byte decode
    logic [7:0]        c;
    logic              is_eos;
    logic              is_q;
    logic              is_sp;
    logic              norm;
    csvfs_pkg::t_qmode d_mode;
    logic              d_close;
    logic              d_eor;
    logic              d_err;
    logic              d_add;
    logic              d_wr_space;
    logic              d_ovf_set;
    logic              d_lead_set;
    logic              d_solid;
    logic              d_last;
    logic [CM_W-1:0]   fi_p1;
    logic [CM_W-1:0]   col_new;
    logic [CM_W-1:0]   col_sel;
    logic [FI_XW-1:0]  fi_x;
    logic [CM_XW-1:0]  cm_x;

    // queue and buffer
    csvfs_pkg::t_out_item q_item;
    logic                 q_push;
    logic                 q_full;
    logic [SC_W-1:0]      rd_idx;
    logic [SA_W-1:0]      ram_raddr;
    logic [7:0]           ram_rdata;

    assign c      = i_in_data.ch;
    assign is_eos = (i_in_data.action == csvfs_pkg::ACT_EOS);
    assign is_q   = (c == csvfs_pkg::CH_QUOTE);
    assign is_sp  = csvfs_pkg::is_space(c);

    always_comb begin : decode
        d_mode  = r_mode;
        d_close = 1'b0;
        d_eor   = 1'b0;
        d_err   = 1'b0;
        d_add   = 1'b0;
        norm    = 1'b0;
        if (is_eos) begin
            d_close = r_line;
            d_eor   = 1'b1;
            d_err   = !r_line && r_hdr && !r_stream;
        end else if (c == csvfs_pkg::CH_LF) begin
            d_close = 1'b1;
            d_eor   = 1'b1;
        end else if (c != csvfs_pkg::CH_CR) begin
            unique case (r_mode)
                csvfs_pkg::QM_QSEEN: begin
                    if (is_q) begin
                        d_mode = csvfs_pkg::QM_QUOTED;
                    end else begin
                        d_mode = csvfs_pkg::QM_NORMAL;
                        norm   = 1'b1;
                    end
                end
                csvfs_pkg::QM_QUOTED: begin
                    if (is_q) begin
                        d_mode = csvfs_pkg::QM_QSEEN;
                    end
                    d_add = 1'b1;
                end
                default: begin
                    norm = 1'b1;
                end
            endcase
            if (norm) begin
                if (c == r_sep) begin
                    d_close = 1'b1;
                end else begin
                    if (is_q) begin
                        d_mode = csvfs_pkg::QM_QUOTED;
                    end
                    d_add = 1'b1;
                end
            end
        end
    end

    assign d_wr_space = d_add && is_sp && r_started && (r_sc < SC_W'(SPACE_DEPTH));
    assign d_ovf_set  = d_add && is_sp && r_started && !(r_sc < SC_W'(SPACE_DEPTH));
    assign d_lead_set = d_add && !is_sp && !r_started && is_q;
    assign d_solid    = d_add && !is_sp && (r_started || !is_q);
    assign d_last     = r_hvalid && !(r_lead && r_held == csvfs_pkg::CH_QUOTE);

    assign fi_p1   = CM_W'(r_fi) + CM_W'(1);
    assign col_new = (d_eor && fi_p1 > r_colmax) ? fi_p1 : r_colmax;
    assign col_sel = (i_cmd.accept && d_close) ? col_new : r_colmax;
    assign fi_x    = FI_XW'(r_fi);
    assign cm_x    = CM_XW'(col_sel);

    always_comb begin : next_state
        n_mode    = r_mode;
        n_started = r_started;
        n_lead    = r_lead;
        n_held    = r_held;
        n_hvalid  = r_hvalid;
        n_sc      = r_sc;
        n_ovf     = r_ovf;
        n_fi      = r_fi;
        n_rec     = r_rec;
        n_colmax  = r_colmax;
        n_line    = r_line;
        n_stream  = r_stream;
        n_fl_idx  = r_fl_idx;
        n_fl_cnt  = r_fl_cnt;
        if (i_cmd.flush_step) begin
            n_fl_idx = r_fl_idx + SC_W'(1);
        end
        if (i_cmd.accept) begin
            if (is_eos) begin
                // end of stream: return parser state and counters to reset values
                n_mode    = csvfs_pkg::QM_NORMAL;
                n_started = 1'b0;
                n_lead    = 1'b0;
                n_held    = 8'd0;
                n_hvalid  = 1'b0;
                n_sc      = '0;
                n_ovf     = 1'b0;
                n_fi      = '0;
                n_rec     = 16'd0;
                n_colmax  = '0;
                n_line    = 1'b0;
                n_stream  = 1'b0;
            end else begin
                n_stream = 1'b1;
                if (c != csvfs_pkg::CH_LF) begin
                    n_line = 1'b1;
                end
                n_mode = d_mode;
                if (d_wr_space) begin
                    n_sc = r_sc + SC_W'(1);
                end
                if (d_ovf_set) begin
                    n_ovf = 1'b1;
                end
                if (d_add && !is_sp && !r_started) begin
                    n_started = 1'b1;
                end
                if (d_lead_set) begin
                    n_lead = 1'b1;
                end
                if (d_solid) begin
                    n_held   = c;
                    n_hvalid = 1'b1;
                    n_sc     = '0;
                    n_fl_cnt = r_sc;
                    n_fl_idx = '0;
                end
                if (d_close) begin
                    n_mode    = csvfs_pkg::QM_NORMAL;
                    n_started = 1'b0;
                    n_lead    = 1'b0;
                    n_held    = 8'd0;
                    n_hvalid  = 1'b0;
                    n_sc      = '0;
                    n_ovf     = 1'b0;
                    if (d_eor) begin
                        n_fi     = '0;
                        n_colmax = col_new;
                        n_line   = 1'b0;
                        if (r_rec != 16'hFFFF) begin
                            n_rec = r_rec + 16'd1;
                        end
                    end else if (r_fi < FI_W'(MAX_FIELDS - 1)) begin
                        n_fi = r_fi + FI_W'(1);
                    end
                end
            end
        end
    end

    always_comb begin : build_result
        q_item.out_char       = 8'd0;
        q_item.char_valid     = 1'b0;
        q_item.end_of_field   = 1'b0;
        q_item.end_of_record  = 1'b0;
        q_item.field_number   = (fi_x > FI_XW'(255)) ? 8'hFF : fi_x[7:0];
        q_item.record_number  = r_rec;
        q_item.is_header      = r_hdr && (r_rec == 16'd0);
        q_item.max_columns    = (cm_x > CM_XW'(511)) ? 9'h1FF : cm_x[8:0];
        q_item.space_overflow = r_ovf;
        q_item.empty_error    = 1'b0;
        q_push                = 1'b0;
        if (i_cmd.flush_step) begin
            q_push            = 1'b1;
            q_item.out_char   = ram_rdata;
            q_item.char_valid = 1'b1;
        end else if (i_cmd.accept) begin
            if (d_err) begin
                q_push                = 1'b1;
                q_item.field_number   = 8'd0;
                q_item.record_number  = 16'd0;
                q_item.is_header      = 1'b0;
                q_item.max_columns    = 9'd0;
                q_item.space_overflow = 1'b0;
                q_item.empty_error    = 1'b1;
            end else if (d_close) begin
                q_push               = 1'b1;
                q_item.out_char      = d_last ? r_held : 8'd0;
                q_item.char_valid    = d_last;
                q_item.end_of_field  = 1'b1;
                q_item.end_of_record = d_eor;
            end else if (d_solid && r_hvalid) begin
                q_push            = 1'b1;
                q_item.out_char   = r_held;
                q_item.char_valid = 1'b1;
            end
        end
    end

    // Read the next buffered space ahead so the data is ready when the queue frees up.
    always_comb begin
        if (i_cmd.flush_step) begin
            rd_idx = r_fl_idx + SC_W'(1);
        end else if (i_cmd.in_flush) begin
            rd_idx = r_fl_idx;
        end else begin
            rd_idx = '0;
        end
        ram_raddr = (rd_idx < SC_W'(SPACE_DEPTH)) ? rd_idx[SA_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep     <= csvfs_pkg::SEP_RESET;
            r_hdr     <= 1'b0;
            r_mode    <= csvfs_pkg::QM_NORMAL;
            r_started <= 1'b0;
            r_lead    <= 1'b0;
            r_held    <= 8'd0;
            r_hvalid  <= 1'b0;
            r_sc      <= '0;
            r_ovf     <= 1'b0;
            r_fi      <= '0;
            r_rec     <= 16'd0;
            r_colmax  <= '0;
            r_line    <= 1'b0;
            r_stream  <= 1'b0;
            r_fl_idx  <= '0;
            r_fl_cnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    csvfs_pkg::REG_SEPARATOR:  r_sep <= i_cfg_wdata[7:0];
                    csvfs_pkg::REG_HAS_HEADER: r_hdr <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            r_mode    <= n_mode;
            r_started <= n_started;
            r_lead    <= n_lead;
            r_held    <= n_held;
            r_hvalid  <= n_hvalid;
            r_sc      <= n_sc;
            r_ovf     <= n_ovf;
            r_fi      <= n_fi;
            r_rec     <= n_rec;
            r_colmax  <= n_colmax;
            r_line    <= n_line;
            r_stream  <= n_stream;
            r_fl_idx  <= n_fl_idx;
            r_fl_cnt  <= n_fl_cnt;
        end
    end

    csvfs_ram #(
        .WIDTH (8),
        .DEPTH (SPACE_DEPTH),
        .AW    (SA_W)
    ) u_space_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && !is_eos && d_wr_space),
        .i_waddr (r_sc[SA_W-1:0]),
        .i_wdata (c),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    csvfs_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_item      (q_item),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_full      (q_full)
    );

    assign o_sts.q_full     = q_full;
    assign o_sts.need_flush = !is_eos && d_solid && (r_sc != '0);
    assign o_sts.flush_last = ((r_fl_idx + SC_W'(1)) == r_fl_cnt);

`ifndef SYNTH
    a_space_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sc <= SC_W'(SPACE_DEPTH))
        else $error("space count beyond buffer depth");

    a_flush_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush_step |-> (r_fl_idx < r_fl_cnt))
        else $error("space replay past buffered count");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("result pushed into full queue");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && is_eos) |=> (r_rec == 16'd0 && r_colmax == '0 && !r_stream
                                      && !r_hvalid && r_sc == '0))
        else $error("stream state not cleared after end of stream");
`endif

endmodule

### src/csvfs_ctrl.sv
// Controller: accepts input bytes and sequences the replay of buffered whitespace.
module csvfs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  csvfs_pkg::t_dp_sts i_sts,
    output csvfs_pkg::t_dp_cmd o_cmd,
    output logic               o_in_stall
);

    csvfs_pkg::t_state r_state;
    csvfs_pkg::t_state n_state;

    always_comb begin : next_state
        n_state = r_state;
        unique case (r_state)
            csvfs_pkg::ST_IDLE: begin
                if (i_in_valid && !i_sts.q_full && i_sts.need_flush) begin
                    n_state = csvfs_pkg::ST_FLUSH;
                end
            end
            csvfs_pkg::ST_FLUSH: begin
                if (!i_sts.q_full && i_sts.flush_last) begin
                    n_state = csvfs_pkg::ST_IDLE;
                end
            end
            default: n_state = csvfs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin : outputs
        o_cmd.accept     = 1'b0;
        o_cmd.flush_step = 1'b0;
        o_cmd.in_flush   = 1'b0;
        o_in_stall       = 1'b1;
        unique case (r_state)
            csvfs_pkg::ST_IDLE: begin
                o_in_stall   = i_sts.q_full;
                o_cmd.accept = i_in_valid && !i_sts.q_full;
            end
            csvfs_pkg::ST_FLUSH: begin
                o_cmd.in_flush   = 1'b1;
                o_cmd.flush_step = !i_sts.q_full;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csvfs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### src/csv_field_splitter.sv
// Top level of the CSV field splitter: controller, datapath and port wiring.
// Latency: results enter a two-entry queue at the accepting edge and show on o_out_valid in
// the next cycle; a byte's own text leaves only when a later byte or the field end frees it.
// Throughput: one byte per cycle; a non-space byte after buffered spaces holds the input
// while the space RAM replays them. A full result queue also holds the input.
// Reset: synchronous, active low; clears parser state, loads separator 44 and has_header 0.
module csv_field_splitter #(
    parameter int SPACE_DEPTH = 16,
    parameter int MAX_FIELDS  = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  csvfs_pkg::t_in_item              i_in_data,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output csvfs_pkg::t_out_item             o_out_data,
    // configuration writes, only while idle
    input  logic                             i_cfg_we,
    input  logic [csvfs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [csvfs_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    csvfs_pkg::t_dp_cmd cmd;
    csvfs_pkg::t_dp_sts sts;

    // Sequence the transaction: accept a byte, or replay buffered spaces one per cycle while the result queue has room.
    csvfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Decode the byte, update field and record state, and queue the results.
    csvfs_datapath #(
        .SPACE_DEPTH (SPACE_DEPTH),
        .MAX_FIELDS  (MAX_FIELDS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
